// ----- hw/rtl/emnd_pkg.sv -----
`timescale 1ns / 1ps

package emnd_pkg;

  // line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = COL_W + 1;

  // field widths
  localparam int PIX_W  = 8;
  localparam int WID_W  = 11;
  localparam int PEND_W = 11;
  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  // rows saturates here
  localparam logic [1:0] ROWS_FULL = 2'd3;
  localparam logic [1:0] ROWS_TWO  = 2'd2;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // one line store entry: pixel plus in-image mark
  typedef struct packed {
    logic             ok;
    logic [PIX_W-1:0] pix;
  } line_entry_t;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- hw/rtl/edge_max_neighbour_difference_top.sv -----
`timescale 1ns / 1ps

// a pixel's result is formed by the step image_width+1 items after the pixel,
//   then passes a judge register and the output register
// throughput: one item per cycle while item_stall is low, set by the line store
//   read-modify-write done every step; the first flush tick of an image with fewer
//   than image_width+1 pixels holds item_stall high and runs empty steps until found
// reset: control state cleared, image_width set to 1, line stores left as they are
module edge_max_neighbour_difference_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write_en,
  input  logic [emnd_pkg::WID_W-1:0]      cfg_write_data,
  // input items
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            kind,
  input  logic [emnd_pkg::PIX_W-1:0]      pixel_value,
  input  logic                            last_pixel,
  // result items
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [emnd_pkg::PIX_W-1:0]      edge_value,
  output logic                            last_edge
);

  // configuration register
  logic [emnd_pkg::WID_W-1:0] image_width;
  logic [emnd_pkg::CNT_W-1:0] w_eff;

  // control state
  logic [emnd_pkg::COL_W-1:0]  col;
  logic [1:0]                  rows;
  logic [emnd_pkg::PEND_W-1:0] pending;
  logic                        draining;
  logic                        busy;          // flush tick still searching for its result

  // 3x3 window: index row*3+column, column 2 is the newest
  logic [emnd_pkg::PIX_W-1:0] wp [9];
  logic [8:0]                 wok;

  // line stores, registered read port plus same-edge forwarding
  emnd_pkg::line_entry_t upper_mem  [emnd_pkg::MAX_WIDTH];
  emnd_pkg::line_entry_t middle_mem [emnd_pkg::MAX_WIDTH];
  emnd_pkg::line_entry_t up_rd, md_rd;
  emnd_pkg::line_entry_t fwd_up, fwd_md;
  logic                  fwd;
  logic [emnd_pkg::COL_W-1:0] raddr;

  // judge stage
  logic                       jv;
  logic [emnd_pkg::PIX_W-1:0] jc;
  logic [emnd_pkg::PIX_W-1:0] jn [8];
  logic [7:0]                 jok;
  logic                       jlast;
  logic [emnd_pkg::PIX_W-1:0] jmax;

  // step logic
  logic o_ready, j_ready, item_acc;
  logic pix_step, flush_go, step, clr_pre;
  logic [emnd_pkg::COL_W-1:0]  col_pre, col_eff, col_adv, col_next;
  logic [emnd_pkg::CNT_W-1:0]  col_inc;
  logic [1:0]                  rows_pre, rows_inc, rows_next;
  logic [emnd_pkg::PEND_W-1:0] pend_pre, pend_inc, pend_after, pending_next;
  logic [8:0]                  wok_pre, wok_next;
  logic [emnd_pkg::PIX_W-1:0]  wp_next [9];
  logic                        draining_next, busy_next;
  logic                        col0, got, fin;
  emnd_pkg::line_entry_t       up_cur, md_cur, new_md;
  logic                        nu_ok, nm_ok;
  logic [emnd_pkg::PIX_W-1:0]  val;

  // width clipped to the line store depth, zero acts as one
  always_comb begin
    if (image_width == '0) begin
      w_eff = emnd_pkg::CNT_W'(1);
    end else if (32'(image_width) > emnd_pkg::MAX_WIDTH) begin
      w_eff = emnd_pkg::CNT_W'(emnd_pkg::MAX_WIDTH);
    end else begin
      w_eff = emnd_pkg::CNT_W'(image_width);
    end
  end

  // handshake: two registers (judge, output) part the input from the result side
  assign o_ready    = !result_valid || !result_stall;
  assign j_ready    = !jv || o_ready;
  assign item_stall = busy || !j_ready;
  assign item_acc   = item_valid && !item_stall;

  // a flush tick only counts while draining with results still due
  assign pix_step = item_acc && (kind == emnd_pkg::KIND_PIXEL);
  assign flush_go = item_acc && (kind == emnd_pkg::KIND_FLUSH) && draining && (pending != '0);
  assign step     = pix_step || flush_go || (busy && j_ready);

  // a pixel arriving while draining starts a fresh image
  assign clr_pre  = pix_step && draining;
  assign col_pre  = clr_pre ? '0 : col;
  assign rows_pre = clr_pre ? '0 : rows;
  assign pend_pre = clr_pre ? '0 : pending;
  assign wok_pre  = clr_pre ? '0 : wok;

  always_comb begin
    col_eff = ({1'b0, col_pre} >= w_eff) ? '0 : col_pre;
    col0    = (col_eff == '0);
    col_inc = {1'b0, col_eff} + emnd_pkg::CNT_W'(1);
    col_adv = (col_inc >= w_eff) ? '0 : col_inc[emnd_pkg::COL_W-1:0];

    rows_inc = (col0 && rows_pre != emnd_pkg::ROWS_FULL) ? rows_pre + 2'd1 : rows_pre;

    // store data for this column, including a write made at the previous edge
    up_cur = fwd ? fwd_up : up_rd;
    md_cur = fwd ? fwd_md : md_rd;
    nu_ok  = (rows_inc == emnd_pkg::ROWS_FULL) && up_cur.ok;
    nm_ok  = (rows_inc >= emnd_pkg::ROWS_TWO) && md_cur.ok;
    val    = pix_step ? pixel_value : '0;
    new_md = '{ok: pix_step, pix: val};

    // the centre is the window's middle row, newest column before the shift
    got = wok_pre[5];

    pend_inc   = (pix_step && pend_pre != emnd_pkg::PEND_MAX) ? pend_pre + 1'b1 : pend_pre;
    pend_after = (got && pend_inc != '0) ? pend_inc - 1'b1 : pend_inc;
    fin        = !pix_step && got && (pend_after == '0);

    // window shift, left edge masked at a row start
    for (int r = 0; r < 3; r++) begin
      wp_next[r*3]     = wp[r*3+1];
      wp_next[r*3+1]   = wp[r*3+2];
      wok_next[r*3]    = wok_pre[r*3+1] && !col0;
      wok_next[r*3+1]  = wok_pre[r*3+2] && !col0;
    end
    wp_next[2]  = up_cur.pix;
    wp_next[5]  = md_cur.pix;
    wp_next[8]  = val;
    wok_next[2] = nu_ok;
    wok_next[5] = nm_ok;
    wok_next[8] = pix_step;
    if (fin) begin
      wok_next = '0;
    end

    col_next      = col;
    rows_next     = rows;
    pending_next  = pending;
    draining_next = draining;
    busy_next     = busy;
    if (step) begin
      col_next      = fin ? '0 : col_adv;
      rows_next     = fin ? '0 : rows_inc;
      pending_next  = fin ? '0 : pend_after;
      draining_next = fin ? 1'b0 : (pix_step ? last_pixel : draining);
      busy_next     = !pix_step && !got;
    end

    raddr = rst ? '0 : col_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= emnd_pkg::WID_W'(1);
      col          <= '0;
      rows         <= '0;
      pending      <= '0;
      draining     <= 1'b0;
      busy         <= 1'b0;
      wok          <= '0;
      fwd          <= 1'b0;
      jv           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        image_width <= cfg_write_data;
      end
      col      <= col_next;
      rows     <= rows_next;
      pending  <= pending_next;
      draining <= draining_next;
      busy     <= busy_next;
      if (step) begin
        wok <= wok_next;
      end
      fwd <= step && (col_next == col_eff);
      if (j_ready) begin
        jv <= step && got;
      end
      if (o_ready) begin
        result_valid <= jv;
      end
    end
  end

  // line stores: write this column, read the next one
  always_ff @(posedge clk) begin
    if (step) begin
      upper_mem[col_eff]  <= md_cur;
      middle_mem[col_eff] <= new_md;
    end
    up_rd <= upper_mem[raddr];
    md_rd <= middle_mem[raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    fwd_up <= md_cur;
    fwd_md <= new_md;
    if (step) begin
      for (int i = 0; i < 9; i++) begin
        wp[i] <= wp_next[i];
      end
    end
    if (j_ready && step && got) begin
      jc    <= wp[5];
      jn[0] <= wp[1];
      jn[1] <= wp[4];
      jn[2] <= wp[7];
      jn[3] <= wp[2];
      jn[4] <= wp[8];
      jn[5] <= up_cur.pix;
      jn[6] <= md_cur.pix;
      jn[7] <= val;
      jok   <= {pix_step && !col0, nm_ok && !col0, nu_ok && !col0,
                wok_pre[8], wok_pre[2], wok_pre[7], wok_pre[4], wok_pre[1]};
      jlast <= fin;
    end
    if (o_ready) begin
      edge_value <= jmax;
      last_edge  <= jlast;
    end
  end

  // largest difference over the in-image neighbours
  always_comb begin
    jmax = '0;
    for (int i = 0; i < 8; i++) begin
      if (jok[i] && emnd_pkg::abs_diff(jn[i], jc) > jmax) begin
        jmax = emnd_pkg::abs_diff(jn[i], jc);
      end
    end
  end

  // a flush search only runs inside a drain
  a_busy_draining: assert property (@(posedge clk) disable iff (rst) busy |-> draining)
    else $error("flush search outside a drain");

  // every step that finds a centre hands it to the judge stage
  a_got_judged: assert property (@(posedge clk) disable iff (rst) (step && got) |=> jv)
    else $error("result of a step lost");

  // the image's final result clears the image state
  a_fin_clear: assert property (@(posedge clk) disable iff (rst)
      (step && fin) |=> (!draining && pending == '0 && col == '0 && !busy))
    else $error("image state not cleared after final result");

  // a held judge entry keeps its contents
  a_judge_hold: assert property (@(posedge clk) disable iff (rst)
      (jv && !o_ready) |=> (jv && $stable(jc) && $stable(jlast)))
    else $error("judge stage changed while held");

  // forwarding only follows a step
  a_fwd_step: assert property (@(posedge clk) disable iff (rst) fwd |-> $past(step))
    else $error("forwarding without a write");

endmodule
